// ===== rtl/mgww_pkg.sv =====
`default_nettype none

package mgww_pkg;

    // fixed field widths of the channels
    localparam int CODE_BITS   = 21;
    localparam int START_BITS  = 16;
    localparam int LENGTH_BITS = 11;
    localparam int LWIDTH_BITS = 10;

    // wrap width after reset
    localparam int MAX_WIDTH_RESET = 80;

    // request opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [CODE_BITS-1:0] NEWLINE_CODE = 21'd10;

    // one input request as held in the input register
    typedef struct packed {
        logic                 op;
        logic [CODE_BITS-1:0] code;
    } mgww_item_t;

    // one wrapped line record
    typedef struct packed {
        logic [START_BITS-1:0]  line_start;
        logic [LENGTH_BITS-1:0] line_length;
        logic [LWIDTH_BITS-1:0] line_width;
        logic                   is_final;
        logic                   too_long;
    } mgww_line_t;

    // unicode white_space property
    function automatic logic is_white(input logic [CODE_BITS-1:0] c);
        logic ws;
        case (c) inside
            [21'd9:21'd13], 21'd32, 21'h85, 21'hA0, 21'h1680,
            [21'h2000:21'h200A], 21'h2028, 21'h2029, 21'h202F,
            21'h205F, 21'h3000: ws = 1'b1;
            default:            ws = 1'b0;
        endcase
        return ws;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mgww_if.sv =====
`default_nettype none

// character stream channel
interface mgww_in_if
    import mgww_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [CODE_BITS-1:0] code;

    modport source (output valid, output op, output code, input ready);
    modport sink   (input valid, input op, input code, output ready);
endinterface

// wrapped line channel
interface mgww_out_if
    import mgww_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [START_BITS-1:0]  line_start;
    logic [LENGTH_BITS-1:0] line_length;
    logic [LWIDTH_BITS-1:0] line_width;
    logic                   is_final;
    logic                   too_long;

    modport source (output valid, output line_start, output line_length,
                    output line_width, output is_final, output too_long,
                    input ready);
    modport sink   (input valid, input line_start, input line_length,
                    input line_width, input is_final, input too_long,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/mgww_in_reg.sv =====
`default_nettype none

module mgww_in_reg
    import mgww_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mgww_in_if.sink     text,
    input  wire logic   advance,
    output logic        item_valid,
    output mgww_item_t  item
);

    logic       valid_reg;
    logic       valid_next;
    mgww_item_t item_reg;
    logic       load;

    // take a new request when empty or when the held one moves on
    assign text.ready = !valid_reg || advance;
    assign load       = text.valid && text.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.op   <= text.op;
            item_reg.code <= text.code;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/mgww_core.sv =====
`default_nettype none

module mgww_core
    import mgww_pkg::*;
#(
    parameter int POS_BITS   = 16,
    parameter int WIDTH_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [WIDTH_BITS-1:0] cfg_data,
    input  wire logic                  fire,
    input  wire mgww_item_t            item,
    output logic                       emit,
    output mgww_line_t                 line
);

    // common width for offsets, lengths and output slices
    localparam int WB1      = WIDTH_BITS + 1;
    localparam int PB1      = POS_BITS + 1;
    localparam int WIDE0    = (PB1 > WB1) ? PB1 : WB1;
    localparam int VAL_BITS = (WIDE0 > START_BITS + 1) ? WIDE0 : START_BITS + 1;

    logic [WIDTH_BITS-1:0] max_width_reg;
    logic [POS_BITS-1:0]   position_reg,   position_next;
    logic [POS_BITS-1:0]   line_begin_reg, line_begin_next;
    logic [POS_BITS-1:0]   last_space_reg, last_space_next;
    logic                  space_seen_reg, space_seen_next;
    logic                  overflow_reg,   overflow_next;

    logic [POS_BITS-1:0]   off;
    logic [POS_BITS-1:0]   sp_len;
    logic [VAL_BITS-1:0]   off_x;
    logic [VAL_BITS-1:0]   off_inc_x;
    logic [VAL_BITS-1:0]   sp_len_x;
    logic [VAL_BITS-1:0]   sp_len_inc_x;
    logic [VAL_BITS-1:0]   w_x;
    logic [VAL_BITS-1:0]   begin_x;
    logic [VAL_BITS-1:0]   begin_plus_w_x;
    logic [VAL_BITS-1:0]   len_x;
    logic [VAL_BITS-1:0]   wid_x;
    logic                  w_nz;
    logic                  below;
    logic                  nl;
    logic                  sp;

    // offsets within the current line
    assign off            = position_reg - line_begin_reg;
    assign sp_len         = last_space_reg - line_begin_reg;
    assign off_x          = VAL_BITS'(off);
    assign off_inc_x      = off_x + VAL_BITS'(1);
    assign sp_len_x       = VAL_BITS'(sp_len);
    assign sp_len_inc_x   = sp_len_x + VAL_BITS'(1);
    assign w_x            = VAL_BITS'(max_width_reg);
    assign begin_x        = VAL_BITS'(line_begin_reg);
    assign begin_plus_w_x = begin_x + w_x;
    assign w_nz           = |max_width_reg;
    assign below          = off_x < w_x;
    assign nl             = item.code == NEWLINE_CODE;
    assign sp             = is_white(item.code);

    // line decision and next state for the held request
    always_comb
    begin
        position_next   = position_reg;
        line_begin_next = line_begin_reg;
        last_space_next = last_space_reg;
        space_seen_next = space_seen_reg;
        overflow_next   = overflow_reg;
        emit            = 1'b0;
        len_x           = off_x;
        wid_x           = off_x;

        if (item.op == OP_END)
        begin
            emit            = w_nz;
            position_next   = '0;
            line_begin_next = '0;
            last_space_next = '0;
            space_seen_next = 1'b0;
            overflow_next   = 1'b0;
        end
        else
        begin
            if (w_nz)
            begin
                if (below)
                begin
                    if (nl)
                    begin
                        emit            = 1'b1;
                        line_begin_next = position_reg + POS_BITS'(1);
                        space_seen_next = 1'b0;
                    end
                    else if (sp && (off != '0))
                    begin
                        last_space_next = position_reg;
                        space_seen_next = 1'b1;
                    end
                end
                else
                begin
                    emit            = 1'b1;
                    space_seen_next = 1'b0;
                    if (nl)
                    begin
                        wid_x           = w_x;
                        line_begin_next = position_reg + POS_BITS'(1);
                    end
                    else if (sp)
                    begin
                        len_x           = off_inc_x;
                        wid_x           = w_x;
                        line_begin_next = position_reg + POS_BITS'(1);
                    end
                    else if (space_seen_reg)
                    begin
                        // break after the last space
                        len_x           = sp_len_inc_x;
                        wid_x           = sp_len_x;
                        line_begin_next = last_space_reg + POS_BITS'(1);
                    end
                    else
                    begin
                        // forced break at the limit
                        len_x           = w_x;
                        wid_x           = w_x;
                        line_begin_next = begin_plus_w_x[POS_BITS-1:0];
                    end
                end
            end
            position_next = position_reg + POS_BITS'(1);
            if (&position_reg)
            begin
                overflow_next = 1'b1;
            end
        end
    end

    // record fields
    assign line.line_start  = begin_x[START_BITS-1:0];
    assign line.line_length = len_x[LENGTH_BITS-1:0];
    assign line.line_width  = wid_x[LWIDTH_BITS-1:0];
    assign line.is_final    = item.op == OP_END;
    assign line.too_long    = overflow_reg;

    // text state and wrap width; a width write restarts the text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg  <= WIDTH_BITS'(MAX_WIDTH_RESET);
            position_reg   <= '0;
            line_begin_reg <= '0;
            last_space_reg <= '0;
            space_seen_reg <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            max_width_reg  <= cfg_data;
            position_reg   <= '0;
            line_begin_reg <= '0;
            last_space_reg <= '0;
            space_seen_reg <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else if (fire)
        begin
            position_reg   <= position_next;
            line_begin_reg <= line_begin_next;
            last_space_reg <= last_space_next;
            space_seen_reg <= space_seen_next;
            overflow_reg   <= overflow_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mgww_out_reg.sv =====
`default_nettype none

module mgww_out_reg
    import mgww_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire mgww_line_t line,
    output logic        free,
    mgww_out_if.source  lines
);

    logic       valid_reg;
    logic       valid_next;
    mgww_line_t line_reg;

    // slot can take a record when empty or being drained
    assign free = !valid_reg || lines.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (lines.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            line_reg <= line;
        end
    end

    assign lines.valid       = valid_reg;
    assign lines.line_start  = line_reg.line_start;
    assign lines.line_length = line_reg.line_length;
    assign lines.line_width  = line_reg.line_width;
    assign lines.is_final    = line_reg.is_final;
    assign lines.too_long    = line_reg.too_long;

endmodule

`default_nettype wire

// ===== rtl/monospace_greedy_word_wrap.sv =====
// channel   direction  fields
// text      in         op, code (character or end of text)
// lines     out        line_start, line_length, line_width, is_final, too_long
// cfg       in         cfg_we, cfg_data (wrap width, restarts the text)
//
// one request per cycle while the output slot is free or being drained
// the pass goes input register -> wrap decision and text state -> output register
// reset clears the text state, sets the wrap width to 80 and empties both registers
// a stalled output holds its record; the held request waits while the output slot
// is full and not being drained, whether or not it makes a record

`default_nettype none

module monospace_greedy_word_wrap
    import mgww_pkg::*;
#(
    parameter int POS_BITS   = 16,
    parameter int WIDTH_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mgww_in_if.sink                    text,
    mgww_out_if.source                 lines,
    input  wire logic                  cfg_we,
    input  wire logic [WIDTH_BITS-1:0] cfg_data
);

    logic       item_valid;
    mgww_item_t item;
    logic       emit;
    mgww_line_t line;
    logic       out_free;
    logic       fire;

    // held request is processed when its record has somewhere to go
    assign fire = item_valid && out_free;

    mgww_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    mgww_core #(
        .POS_BITS   (POS_BITS),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .fire     (fire),
        .item     (item),
        .emit     (emit),
        .line     (line)
    );

    mgww_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire && emit),
        .line  (line),
        .free  (out_free),
        .lines (lines)
    );

endmodule

`default_nettype wire
